// File: src/trc_pkg.sv
package trc_pkg;

  localparam int MUL_DIGIT = 32;
  localparam int QUOT_BITS = 34;
  localparam int QUOT_W    = QUOT_BITS + 2;
  localparam int ROOT_BITS = 35;
  localparam logic [30:0] RADIUS_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] x_a;
    logic signed [31:0] y_a;
    logic signed [31:0] x_b;
    logic signed [31:0] y_b;
    logic signed [31:0] x_c;
    logic signed [31:0] y_c;
    logic [30:0]        opp_len_a;
    logic [30:0]        opp_len_b;
    logic [30:0]        opp_len_c;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] circ_x;
    logic signed [31:0] circ_y;
    logic [30:0]        circ_radius;
    logic               circ_valid;
    logic signed [63:0] twice_area;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_radius;
    logic               in_valid;
    logic               overflow;
  } out_item_t;

endpackage

// File: src/trc_if.sv
interface trc_in_if import trc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trc_out_if import trc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/triangle_circle_radii_unit.sv
// Triangle circumcircle and incircle unit.
// in_ch carries one triangle per transaction: three vertices and the three
// side lengths, each opposite its vertex. out_ch returns one transaction per
// triangle, in order: circumcentre and circumradius, twice the signed area,
// incentre and inradius, validity flags and a saturation flag.
// Both channels use valid/ready; a transaction completes when both are high.
// Throughput is one triangle per cycle unless a held output result freezes the
// pipeline: multipliers work one 32-bit digit per stage, the five dividers
// resolve one quotient bit per stage and the circumradius root one bit per
// stage, all pipelined.
// Results wait in an output register. While it is held, the pipeline keeps
// moving and accepting as long as its last stage is empty; once a finished
// result reaches that stage the whole pipeline freezes, and in_ch.ready
// drops, until out_ch takes the held result.
// Synchronous reset clears every pipeline valid bit and the output valid.
module triangle_circle_radii_unit import trc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  trc_in_if.sink   in_ch,
  trc_out_if.source out_ch
);

  logic en;
  logic vtail;
  logic out_valid_r;
  out_item_t out_r, out_nxt;

  // stage 1
  logic               v1_r;
  logic signed [32:0] dx1_r, dy1_r, dx2_r, dy2_r, exa_r, eya_r, sbx_r, sby_r;
  logic [32:0]        per_r;
  logic signed [31:0] xa_r, ya_r, xb_r, yb_r, xc_r, yc_r;
  logic [30:0]        la_r, lb_r, lc_r;

  assign en = !(out_valid_r && !out_ch.ready && vtail);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= 33'(in_ch.data.x_b) - 33'(in_ch.data.x_a);
      dy1_r <= 33'(in_ch.data.y_b) - 33'(in_ch.data.y_a);
      dx2_r <= 33'(in_ch.data.x_c) - 33'(in_ch.data.x_b);
      dy2_r <= 33'(in_ch.data.y_c) - 33'(in_ch.data.y_b);
      exa_r <= 33'(in_ch.data.x_a) - 33'(in_ch.data.x_c);
      eya_r <= 33'(in_ch.data.y_a) - 33'(in_ch.data.y_c);
      sbx_r <= 33'(in_ch.data.x_b) + 33'(in_ch.data.x_c);
      sby_r <= 33'(in_ch.data.y_b) + 33'(in_ch.data.y_c);
      per_r <= 33'(in_ch.data.opp_len_a) + 33'(in_ch.data.opp_len_b)
             + 33'(in_ch.data.opp_len_c);
      xa_r  <= in_ch.data.x_a;
      ya_r  <= in_ch.data.y_a;
      xb_r  <= in_ch.data.x_b;
      yb_r  <= in_ch.data.y_b;
      xc_r  <= in_ch.data.x_c;
      yc_r  <= in_ch.data.y_c;
      la_r  <= in_ch.data.opp_len_a;
      lb_r  <= in_ch.data.opp_len_b;
      lc_r  <= in_ch.data.opp_len_c;
    end
  end

  trc_dly #(.W(1), .D(82), .RST(1'b1)) u_vld (
    .clk, .rst_n, .en, .d(v1_r), .q(vtail)
  );

  // determinant and circumcentre numerator terms
  logic signed [65:0] p_d0, p_d1, p_n0, p_n1;

  trc_mul #(.WA(33), .WB(33)) u_md0 (.clk, .en, .a(dx1_r), .b(dy2_r), .p(p_d0));
  trc_mul #(.WA(33), .WB(33)) u_md1 (.clk, .en, .a(dx2_r), .b(dy1_r), .p(p_d1));
  trc_mul #(.WA(33), .WB(33)) u_mn0 (.clk, .en, .a(exa_r), .b(dx1_r), .p(p_n0));
  trc_mul #(.WA(33), .WB(33)) u_mn1 (.clk, .en, .a(eya_r), .b(dy1_r), .p(p_n1));

  // length-weighted vertex sums
  logic signed [63:0] p_xa, p_xb, p_xc, p_ya, p_yb, p_yc;

  trc_mul #(.WA(32), .WB(32)) u_mxa (.clk, .en, .a(xa_r), .b($signed({1'b0, la_r})),
                                     .p(p_xa));
  trc_mul #(.WA(32), .WB(32)) u_mxb (.clk, .en, .a(xb_r), .b($signed({1'b0, lb_r})),
                                     .p(p_xb));
  trc_mul #(.WA(32), .WB(32)) u_mxc (.clk, .en, .a(xc_r), .b($signed({1'b0, lc_r})),
                                     .p(p_xc));
  trc_mul #(.WA(32), .WB(32)) u_mya (.clk, .en, .a(ya_r), .b($signed({1'b0, la_r})),
                                     .p(p_ya));
  trc_mul #(.WA(32), .WB(32)) u_myb (.clk, .en, .a(yb_r), .b($signed({1'b0, lb_r})),
                                     .p(p_yb));
  trc_mul #(.WA(32), .WB(32)) u_myc (.clk, .en, .a(yc_r), .b($signed({1'b0, lc_r})),
                                     .p(p_yc));

  // stage 3
  logic signed [64:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= 65'(p_xa) + 65'(p_xb) + 65'(p_xc);
      sy_r <= 65'(p_ya) + 65'(p_yb) + 65'(p_yc);
    end
  end

  // stage 4
  logic signed [66:0] den_r, num2_r;
  logic [129:0]       sxy4;
  logic [164:0]       b4;
  logic signed [64:0] sx4, sy4;
  logic [32:0]        per4;
  logic signed [32:0] sbx4, sby4, dy24, dx24;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= 67'(p_d0) - 67'(p_d1);
      num2_r <= 67'(p_n0) + 67'(p_n1);
    end
  end

  trc_dly #(.W(130), .D(1)) u_dsxy (
    .clk, .rst_n, .en, .d({sx_r, sy_r}), .q(sxy4)
  );
  trc_dly #(.W(165), .D(3)) u_db4 (
    .clk, .rst_n, .en, .d({per_r, sbx_r, sby_r, dy2_r, dx2_r}), .q(b4)
  );

  assign sx4  = $signed(sxy4[129:65]);
  assign sy4  = $signed(sxy4[64:0]);
  assign per4 = b4[164:132];
  assign sbx4 = $signed(b4[131:99]);
  assign sby4 = $signed(b4[98:66]);
  assign dy24 = $signed(b4[65:33]);
  assign dx24 = $signed(b4[32:0]);

  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647)       return {1'b1, 32'h7fff_ffff};
    else if (v < -36'sd2147483648) return {1'b1, 32'h8000_0000};
    else                           return {1'b0, v[31:0]};
  endfunction

  // stage 5: incircle operands, area saturation
  logic signed [68:0] nix_r, niy_r, nir_r;
  logic [33:0]        dpr_r;
  logic               pnz_r, aov_r;
  logic [63:0]        area_r;
  logic signed [68:0] per69;

  assign per69 = 69'($signed({1'b0, per4}));

  always_ff @(posedge clk) begin
    if (en) begin
      nix_r <= (69'(sx4) <<< 1) + per69;
      niy_r <= (69'(sy4) <<< 1) + per69;
      nir_r <= (69'(den_r) <<< 1) + per69;
      dpr_r <= {per4, 1'b0};
      pnz_r <= per4 != '0;
      if (den_r > 67'sh0_7fff_ffff_ffff_ffff) begin
        area_r <= 64'h7fff_ffff_ffff_ffff;
        aov_r  <= 1'b1;
      end else if (den_r < -67'sh0_8000_0000_0000_0000) begin
        area_r <= 64'h8000_0000_0000_0000;
        aov_r  <= 1'b1;
      end else begin
        area_r <= den_r[63:0];
        aov_r  <= 1'b0;
      end
    end
  end

  logic signed [QUOT_W-1:0] qix, qiy, qir;

  trc_div #(.WN(69), .WD(34)) u_dix (.clk, .en, .n(nix_r), .d(dpr_r), .q(qix));
  trc_div #(.WN(69), .WD(34)) u_diy (.clk, .en, .n(niy_r), .d(dpr_r), .q(qiy));
  trc_div #(.WN(69), .WD(34)) u_dir (.clk, .en, .n(nir_r), .d(dpr_r), .q(qir));

  logic [3*QUOT_W-1:0] i83;
  logic [65:0]         m83;

  trc_dly #(.W(3*QUOT_W), .D(42)) u_dinc (
    .clk, .rst_n, .en, .d({qix, qiy, qir}), .q(i83)
  );
  trc_dly #(.W(66), .D(78)) u_dmisc (
    .clk, .rst_n, .en, .d({pnz_r, aov_r, area_r}), .q(m83)
  );

  // circumcentre numerators
  logic signed [99:0] p_cxa, p_cxb, p_cya, p_cyb;

  trc_mul #(.WA(33), .WB(67)) u_mcxa (.clk, .en, .a(sbx4), .b(den_r),  .p(p_cxa));
  trc_mul #(.WA(33), .WB(67)) u_mcxb (.clk, .en, .a(dy24), .b(num2_r), .p(p_cxb));
  trc_mul #(.WA(33), .WB(67)) u_mcya (.clk, .en, .a(sby4), .b(den_r),  .p(p_cya));
  trc_mul #(.WA(33), .WB(67)) u_mcyb (.clk, .en, .a(dx24), .b(num2_r), .p(p_cyb));

  logic [66:0] den7;

  trc_dly #(.W(67), .D(3)) u_dden (.clk, .rst_n, .en, .d(den_r), .q(den7));

  // stage 8
  logic signed [101:0] nx_r, ny_r;
  logic [67:0]         ddn_r;
  logic                cpos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= 102'(p_cxa) + 102'(p_cxb) + 102'($signed(den7));
      ny_r   <= 102'(p_cya) - 102'(p_cyb) + 102'($signed(den7));
      ddn_r  <= {den7, 1'b0};
      cpos_r <= !den7[66] && (den7 != '0);
    end
  end

  logic signed [QUOT_W-1:0] qx, qy;

  trc_div #(.WN(102), .WD(68)) u_dcx (.clk, .en, .n(nx_r), .d(ddn_r), .q(qx));
  trc_div #(.WN(102), .WD(68)) u_dcy (.clk, .en, .n(ny_r), .d(ddn_r), .q(qy));

  logic        cpos44;
  logic [63:0] xy44;

  trc_dly #(.W(1), .D(36)) u_dcpos (.clk, .rst_n, .en, .d(cpos_r), .q(cpos44));
  trc_dly #(.W(64), .D(43)) u_dxy (.clk, .rst_n, .en, .d({xa_r, ya_r}), .q(xy44));

  // stage 45: distance from first vertex, circumcentre saturation
  logic signed [36:0] exf, eyf;
  logic [32:0]        satx, saty;
  logic signed [32:0] exq_r, eyq_r;
  logic               rin_r, pov_r, cp45_r;
  logic [31:0]        pxc_r, pyc_r;

  assign exf  = 37'($signed(xy44[63:32])) - 37'(qx);
  assign eyf  = 37'($signed(xy44[31:0])) - 37'(qy);
  assign satx = sat32(qx);
  assign saty = sat32(qy);

  always_ff @(posedge clk) begin
    if (en) begin
      exq_r  <= $signed(exf[32:0]);
      eyq_r  <= $signed(eyf[32:0]);
      rin_r  <= (exf < 37'sd4294967296) && (exf > -37'sd4294967296)
             && (eyf < 37'sd4294967296) && (eyf > -37'sd4294967296);
      pov_r  <= satx[32] | saty[32];
      pxc_r  <= satx[31:0];
      pyc_r  <= saty[31:0];
      cp45_r <= cpos44;
    end
  end

  logic signed [65:0] p_ex, p_ey;

  trc_mul #(.WA(33), .WB(33)) u_mex (.clk, .en, .a(exq_r), .b(exq_r), .p(p_ex));
  trc_mul #(.WA(33), .WB(33)) u_mey (.clk, .en, .a(eyq_r), .b(eyq_r), .p(p_ey));

  logic [66:0] s83;

  trc_dly #(.W(67), .D(38)) u_dside (
    .clk, .rst_n, .en, .d({rin_r, pov_r, cp45_r, pxc_r, pyc_r}), .q(s83)
  );

  // stage 48: 4 * squared distance into the root unit
  logic signed [66:0]      dsq;
  logic [2*ROOT_BITS-1:0]  sv_r;
  logic [ROOT_BITS-1:0]    root83;

  assign dsq = 67'(p_ex) + 67'(p_ey);

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r <= (2*ROOT_BITS)'({dsq[65:0], 2'b00});
    end
  end

  trc_sqrt #(.N(ROOT_BITS)) u_sqrt (.clk, .en, .v(sv_r), .root(root83));

  // output assembly
  logic [ROOT_BITS:0]   rsum;
  logic [ROOT_BITS-1:0] rr;
  logic [32:0]          satix, satiy, satir;
  logic                 ov;

  assign rsum  = {1'b0, root83} + (ROOT_BITS+1)'(1);
  assign rr    = rsum[ROOT_BITS:1];
  assign satix = sat32(i83[3*QUOT_W-1 -: QUOT_W]);
  assign satiy = sat32(i83[2*QUOT_W-1 -: QUOT_W]);
  assign satir = sat32(i83[QUOT_W-1:0]);

  always_comb begin
    out_nxt            = '0;
    ov                 = m83[64];
    out_nxt.twice_area = $signed(m83[63:0]);
    if (s83[64]) begin
      out_nxt.circ_valid = 1'b1;
      out_nxt.circ_x     = $signed(s83[63:32]);
      out_nxt.circ_y     = $signed(s83[31:0]);
      ov                 = ov | s83[65];
      if (!s83[66]) begin
        out_nxt.circ_radius = RADIUS_MAX;
        ov                  = 1'b1;
      end else if (rr > ROOT_BITS'(RADIUS_MAX)) begin
        out_nxt.circ_radius = RADIUS_MAX;
        ov                  = 1'b1;
      end else begin
        out_nxt.circ_radius = rr[30:0];
      end
    end
    if (m83[65]) begin
      out_nxt.in_valid  = 1'b1;
      out_nxt.in_x      = $signed(satix[31:0]);
      out_nxt.in_y      = $signed(satiy[31:0]);
      out_nxt.in_radius = $signed(satir[31:0]);
      ov                = ov | satix[32] | satiy[32] | satir[32];
    end
    out_nxt.overflow = ov;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= vtail;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vtail))
    else $error("pipeline tail moved during stall");

  a_circ_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.circ_valid |->
      out_r.circ_x == 0 && out_r.circ_y == 0 && out_r.circ_radius == 0)
    else $error("circumcircle fields not cleared");

  a_in_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.in_valid |->
      out_r.in_x == 0 && out_r.in_y == 0 && out_r.in_radius == 0)
    else $error("incircle fields not cleared");

  a_circ_vs_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.circ_valid == (out_r.twice_area > 0))
    else $error("circumcircle valid disagrees with area sign");

endmodule

// File: src/trc_dly.sv
module trc_dly #(
  parameter int W   = 1,
  parameter int D   = 1,
  parameter bit RST = 1'b0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (RST && !rst_n) begin
      for (int i = 0; i < D; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

// File: src/trc_mul.sv
// one 32-bit digit of b per stage
module trc_mul import trc_pkg::*; #(
  parameter int WA = 33,
  parameter int WB = 33,
  parameter int WP = WA + WB
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WP-1:0] p
);

  localparam int DW  = MUL_DIGIT;
  localparam int ND  = (WB + DW - 1) / DW;
  localparam int WBE = ND * DW;
  localparam int WX  = WA + WBE + 1;

  logic signed [WBE-1:0] b_ext;
  logic signed [WA-1:0]  a_r   [ND];
  logic signed [WBE-1:0] b_r   [ND];
  logic signed [WX-1:0]  acc_r [ND];

  assign b_ext = WBE'(b);

  for (genvar k = 0; k < ND; k++) begin : g_stg
    logic signed [WA-1:0]  a_in;
    logic signed [WBE-1:0] b_in;
    logic signed [WX-1:0]  acc_in;
    logic signed [DW:0]    dig;
    logic signed [WA+DW:0] prod;
    logic signed [WX-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = b_ext;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    if (k == ND - 1) begin : g_top
      assign dig = $signed({b_in[WBE-1], b_in[DW*k +: DW]});
    end else begin : g_low
      assign dig = $signed({1'b0, b_in[DW*k +: DW]});
    end

    assign prod    = a_in * dig;
    assign acc_nxt = acc_in + (WX'(prod) <<< (DW * k));

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign p = $signed(acc_r[ND-1][WP-1:0]);

endmodule

// File: src/trc_div.sv
// floor(n / d), d > 0, one quotient bit per stage.
// Quotients of more than K bits come out as +2^K or -2^K-1.
module trc_div import trc_pkg::*; #(
  parameter int WN = 69,
  parameter int WD = 34,
  parameter int K  = QUOT_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WN-1:0] n,
  input  logic [WD-1:0]        d,
  output logic signed [K+1:0]  q
);

  localparam int QW = K + 2;
  localparam int WC = ((WN > WD + K) ? WN : WD + K) + 1;
  localparam logic [QW-1:0] QPOS = QW'(1) << K;

  logic [WN-1:0] rem_r [K+1];
  logic [K-1:0]  quo_r [K+1];
  logic [WD-1:0] d_r   [K+1];
  logic          neg_r [K+1];
  logic          big_r [K+1];
  logic [QW-1:0] res_r;
  logic [WN-1:0] mag;
  logic [QW-1:0] uq;

  assign mag = n[WN-1] ? ~n : n;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag;
      quo_r[0] <= '0;
      d_r[0]   <= d;
      neg_r[0] <= n[WN-1];
      big_r[0] <= WC'(mag) >= (WC'(d) << K);
    end
  end

  for (genvar j = 1; j <= K; j++) begin : g_stg
    localparam int SH = K - j;
    logic [WC-1:0] dsh;
    logic          ge;
    logic [WN-1:0] rem_nxt;
    logic [K-1:0]  quo_nxt;

    assign dsh     = WC'(d_r[j-1]) << SH;
    assign ge      = WC'(rem_r[j-1]) >= dsh;
    assign rem_nxt = ge ? WN'(WC'(rem_r[j-1]) - dsh) : rem_r[j-1];

    always_comb begin
      quo_nxt     = quo_r[j-1];
      quo_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        d_r[j]   <= d_r[j-1];
        neg_r[j] <= neg_r[j-1];
        big_r[j] <= big_r[j-1];
      end
    end
  end

  assign uq = QW'(quo_r[K]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (big_r[K]) res_r <= neg_r[K] ? ~QPOS : QPOS;
      else          res_r <= neg_r[K] ? ~uq : uq;
    end
  end

  assign q = $signed(res_r);

endmodule

// File: src/trc_sqrt.sv
// floor(sqrt(v)), one root bit per stage
module trc_sqrt import trc_pkg::*; #(
  parameter int N = ROOT_BITS
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] v,
  output logic [N-1:0]   root
);

  localparam int RW = N + 2;

  logic [RW-1:0]  rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic [2*N-1:0] v_r    [N];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [RW-1:0]  rem_in;
    logic [N-1:0]   root_in;
    logic [2*N-1:0] v_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = v;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], v_in[2*N-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_in[N-2:0], ge};
        v_r[k]    <= {v_in[2*N-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[N-1];

endmodule

// File: sim/tb_top.sv
module tb_top;
  import trc_pkg::*;

  typedef logic signed [159:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trc_in_if  in_if ();
  trc_out_if out_if ();

  triangle_circle_radii_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t  tri_q[$];
  out_item_t circle_q[$];
  int        cyc = 0;
  int        hold_cycles = 0;
  int        mismatches = 0;

  function automatic wide_t clamp_wide(wide_t v, wide_t lo, wide_t hi, inout logic ov);
    if (v < lo) begin
      ov = 1'b1;
      return lo;
    end
    if (v > hi) begin
      ov = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic wide_t sat32(wide_t v, inout logic ov);
    return clamp_wide(v, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1, ov);
  endfunction

  // nearest, ties toward +inf: floor((2n+d)/(2d))
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t t, dd, q;
    t  = 2 * n + d;
    dd = 2 * d;
    q  = t / dd;
    if (t < 0 && q * dd != t) q = q - 1;
    return q;
  endfunction

  function automatic wide_t int_sqrt(wide_t v);
    wide_t r, c;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic out_item_t predict_circles(in_item_t t);
    wide_t xa, ya, xb, yb, xc, yc, la, lb, lc, per;
    wide_t dx1, dy1, dx2, dy2, den, num2, dd, px, py, ex, ey, s, lim, root;
    logic ov;
    out_item_t r;
    xa = wide_t'(t.x_a); ya = wide_t'(t.y_a);
    xb = wide_t'(t.x_b); yb = wide_t'(t.y_b);
    xc = wide_t'(t.x_c); yc = wide_t'(t.y_c);
    la = wide_t'(t.opp_len_a); lb = wide_t'(t.opp_len_b); lc = wide_t'(t.opp_len_c);
    per = la + lb + lc;
    ov = 1'b0;
    r = '0;
    dx1 = xb - xa; dy1 = yb - ya;
    dx2 = xc - xb; dy2 = yc - yb;
    den = dx1 * dy2 - dx2 * dy1;
    if (den > 0) begin
      num2 = (xa - xc) * dx1 + (ya - yc) * dy1;
      dd = den + den;
      px = round_div((xb + xc) * den + num2 * dy2, dd);
      py = round_div((yb + yc) * den - num2 * dx2, dd);
      ex = xa - px;
      ey = ya - py;
      lim = wide_t'(1) <<< 32;
      r.circ_valid = 1'b1;
      r.circ_x = 32'(sat32(px, ov));
      r.circ_y = 32'(sat32(py, ov));
      if (ex < lim && ex > -lim && ey < lim && ey > -lim) begin
        s = ex * ex + ey * ey;
        root = (int_sqrt(4 * s) + 1) >>> 1;
        if (root > wide_t'(RADIUS_MAX)) begin
          root = wide_t'(RADIUS_MAX);
          ov = 1'b1;
        end
        r.circ_radius = 31'(root);
      end else begin
        r.circ_radius = RADIUS_MAX;
        ov = 1'b1;
      end
    end
    r.twice_area = 64'(clamp_wide(den, -(wide_t'(1) <<< 63), (wide_t'(1) <<< 63) - 1, ov));
    if (per != 0) begin
      r.in_valid  = 1'b1;
      r.in_x      = 32'(sat32(round_div(xa * la + xb * lb + xc * lc, per), ov));
      r.in_y      = 32'(sat32(round_div(ya * la + yb * lb + yc * lc, per), ov));
      r.in_radius = 32'(sat32(round_div(den, per), ov));
    end
    r.overflow = ov;
    return r;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
  endfunction

  function automatic in_item_t rand_triangle();
    in_item_t t;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      t.x_a = small_coord(); t.y_a = small_coord();
      t.x_b = small_coord(); t.y_b = small_coord();
      t.x_c = small_coord(); t.y_c = small_coord();
      t.opp_len_a = 31'($urandom_range(0, 32'h003f_ffff));
      t.opp_len_b = 31'($urandom_range(0, 32'h003f_ffff));
      t.opp_len_c = 31'($urandom_range(0, 32'h003f_ffff));
      if (mode == 6) begin
        t.x_c = t.x_a + (t.x_b - t.x_a) * 2;
        t.y_c = t.y_a + (t.y_b - t.y_a) * 2;
        t.opp_len_a = '0; t.opp_len_b = '0; t.opp_len_c = '0;
      end
    end else begin
      t.x_a = $urandom(); t.y_a = $urandom();
      t.x_b = $urandom(); t.y_b = $urandom();
      t.x_c = $urandom(); t.y_c = $urandom();
      t.opp_len_a = 31'($urandom());
      t.opp_len_b = 31'($urandom());
      t.opp_len_c = 31'($urandom());
    end
    return t;
  endfunction

  function automatic in_item_t make_tri(int xa, int ya, int xb, int yb, int xc, int yc,
                                        int la, int lb, int lc);
    in_item_t t;
    t.x_a = xa; t.y_a = ya; t.x_b = xb; t.y_b = yb; t.x_c = xc; t.y_c = yc;
    t.opp_len_a = 31'(la); t.opp_len_b = 31'(lb); t.opp_len_c = 31'(lc);
    return t;
  endfunction

  function automatic bit fields_differ(out_item_t a, out_item_t e);
    return a.circ_x !== e.circ_x || a.circ_y !== e.circ_y ||
           a.circ_radius !== e.circ_radius || a.circ_valid !== e.circ_valid ||
           a.twice_area !== e.twice_area || a.in_x !== e.in_x || a.in_y !== e.in_y ||
           a.in_radius !== e.in_radius || a.in_valid !== e.in_valid ||
           a.overflow !== e.overflow;
  endfunction

  function automatic bit idle_roll();
    if (cyc >= 100 && cyc < 250) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // driver
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) circle_q.push_back(predict_circles(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (tri_q.size() > 0 && !idle_roll()) begin
          in_if.valid <= 1'b1;
          in_if.data  <= tri_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor; one long hold-off to back the pipeline up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (circle_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", out_if.data);
        end else begin
          out_item_t e;
          e = circle_q.pop_front();
          if (fields_differ(out_if.data, e)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch\n  expected %p\n  actual   %p", e, out_if.data);
          end
        end
      end
      if (cyc == 400) begin
        hold_cycles <= 300;
        out_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !idle_roll();
      end
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff));
    tri_q.push_back(make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 1, 0, 0));
    tri_q.push_back(make_tri(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h16a0a, 32'h10000,
                             32'h10000));
    tri_q.push_back(make_tri(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h16a0a, 32'h10000,
                             32'h10000));
    tri_q.push_back(make_tri(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 5, 6, 7));
    tri_q.push_back(make_tri(0, 0, 32'h100000, 1, 32'h200000, 0, 9, 9, 9));
    tri_q.push_back(make_tri(0, 0, 32'h200000, 0, 32'h100000, 1, 9, 9, 9));
    tri_q.push_back(make_tri(0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0));
    tri_q.push_back(make_tri(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff));
    tri_q.push_back(make_tri(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h80000000, 1, 1, 1));
    tri_q.push_back(make_tri(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff));
    tri_q.push_back(make_tri(-1, -1, 0, -1, -1, 0, 1, 1, 1));
    tri_q.push_back(make_tri(0, 0, 1, 0, 0, 1, 0, 0, 1));
    tri_q.push_back(make_tri(-5, 3, 7, -2, 1, 9, 3, 0, 0));
    tri_q.push_back(make_tri(32'h40000000, 0, 32'hc0000000, 0, 0, 32'h40000000,
                             32'h7fffffff, 0, 32'h7fffffff));
    for (int i = 0; i < 600; i++) tri_q.push_back(rand_triangle());
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (tri_q.size() == 0);
    @(posedge clk);
    while (in_if.valid) @(posedge clk);
    while (circle_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0 && circle_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("Mismatches found");
    $finish;
  end

endmodule
